@@ design/hbs_pkg.sv @@
`default_nettype none

package hbs_pkg;

  // Grid limits and result format
  localparam int MAX_GRID_WIDTH  = 256;
  localparam int MAX_GRID_HEIGHT = 256;
  localparam int FRAC_BITS       = 12;

  // Fixed field formats
  localparam int GRID_FRAC = 12;   // fraction bits of the grid coordinate
  localparam int WORLD_W   = 24;   // world_x / world_z width
  localparam int CFG_W     = 9;    // grid_width / grid_height width
  localparam int HEIGHT_W  = 8;    // stored height width
  localparam int OUT_W     = 20;   // height_value width
  localparam int INDEX_W   = 16;   // cell_index width

  // Derived sizes
  localparam int COL_W       = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W       = $clog2(MAX_GRID_HEIGHT);
  localparam int STORE_DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CELL_RAW_W  = WORLD_W - GRID_FRAC;
  localparam int TOP_W       = HEIGHT_W + FRAC_BITS;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Config register indexes
  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_index_t;

  // Per-query side info carried alongside the memory read
  typedef struct packed {
    logic                 inr;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;
  } hbs_tag_t;

  // Grid fraction rescaled to FRAC_BITS (zero pad or truncate)
  function automatic logic [FRAC_BITS-1:0] frac_conv(input logic [GRID_FRAC-1:0] f);
    logic [GRID_FRAC+FRAC_BITS-1:0] t;
    t = {f, {FRAC_BITS{1'b0}}} >> GRID_FRAC;
    return t[FRAC_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/hbs_ram.sv @@
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

@@ design/hbs_lerp.sv @@
`default_nettype none

module hbs_lerp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s1_valid,
  input  wire hbs_pkg::hbs_tag_t             s1_tag,
  output logic                               s1_ready,
  input  wire logic [hbs_pkg::HEIGHT_W-1:0]  h00,
  input  wire logic [hbs_pkg::HEIGHT_W-1:0]  h10,
  input  wire logic [hbs_pkg::HEIGHT_W-1:0]  h01,
  input  wire logic [hbs_pkg::HEIGHT_W-1:0]  h11,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [hbs_pkg::OUT_W-1:0]     height_value,
  output logic                               in_range
);

  localparam int FB  = hbs_pkg::FRAC_BITS;
  localparam int TW  = hbs_pkg::TOP_W;
  localparam int SW1 = TW + 2;
  localparam int SW2 = TW + FB + 2;

  logic en_out, en3;

  // stage 2: heights from RAM, tag here
  logic              v2;
  hbs_pkg::hbs_tag_t tag2;

  // stage 3: row blends
  logic          v3;
  logic          inr3;
  logic [FB-1:0] fz3;
  logic [TW-1:0] top3, bot3;

  assign en_out   = !out_valid || out_ready;
  assign en3      = !v3 || en_out;
  assign s1_ready = !v2 || en3;

  // row blend: a*one + (b-a)*f
  logic signed [SW1-1:0] fx_e, dtop_e, dbot_e, a_top_e, a_bot_e, top_s, bot_s;

  always_comb begin
    fx_e    = SW1'({1'b0, tag2.fx});
    dtop_e  = SW1'({1'b0, h10}) - SW1'({1'b0, h00});
    dbot_e  = SW1'({1'b0, h11}) - SW1'({1'b0, h01});
    a_top_e = SW1'({1'b0, h00}) <<< FB;
    a_bot_e = SW1'({1'b0, h01}) <<< FB;
    top_s   = a_top_e + dtop_e * fx_e;
    bot_s   = a_bot_e + dbot_e * fx_e;
  end

  // column blend
  logic signed [SW2-1:0] fz_e, t_e, b_e, sum_s, val_s;

  always_comb begin
    fz_e  = SW2'({1'b0, fz3});
    t_e   = SW2'({1'b0, top3});
    b_e   = SW2'({1'b0, bot3});
    sum_s = (t_e <<< FB) + (b_e - t_e) * fz_e;
    val_s = sum_s >>> FB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) v2 <= s1_valid;
      if (en3)      v3 <= v2;
      if (en_out)   out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      tag2 <= s1_tag;
    end
    if (en3) begin
      inr3 <= tag2.inr;
      fz3  <= tag2.fz;
      top3 <= top_s[TW-1:0];
      bot3 <= bot_s[TW-1:0];
    end
    if (en_out) begin
      in_range     <= inr3;
      height_value <= inr3 ? hbs_pkg::OUT_W'(val_s) : '0;
    end
  end

endmodule

`default_nettype wire

@@ design/heightmap_bilinear_sample_top.sv @@
// Bilinear heightfield sampler: height writes and interpolated queries.
// A query passes the address stage, memory read, row blend and column blend
// into the output register. Throughput: one item per cycle unless out_ready
// stalls the pipe; writes give no result.
// Reset: rst is synchronous; it clears the pipeline valids and sets both grid
// dimensions to 256. Height store contents are undefined until written.
`default_nettype none

module heightmap_bilinear_sample_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic [hbs_pkg::INDEX_W-1:0]         cell_index,
  input  wire logic [hbs_pkg::HEIGHT_W-1:0]        cell_height,
  input  wire logic signed [hbs_pkg::WORLD_W-1:0]  world_x,
  input  wire logic signed [hbs_pkg::WORLD_W-1:0]  world_z,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hbs_pkg::OUT_W-1:0]                height_value,
  output logic                                     in_range,
  // config channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [hbs_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = hbs_pkg::ADDR_W;
  localparam int CW = hbs_pkg::CELL_RAW_W;

  // ---------------------------------------------------------------------------
  // Config registers. Always ready; writes must only be issued while idle (not enforced here).
  // ---------------------------------------------------------------------------
  logic [hbs_pkg::CFG_W-1:0] grid_width, grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= hbs_pkg::CFG_W'(256);
      grid_height <= hbs_pkg::CFG_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        hbs_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        hbs_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions clamped to the store geometry
  logic [hbs_pkg::CFG_W-1:0] w_sat, h_sat;

  assign w_sat = (32'(grid_width) > hbs_pkg::MAX_GRID_WIDTH) ?
                 hbs_pkg::CFG_W'(hbs_pkg::MAX_GRID_WIDTH) : grid_width;
  assign h_sat = (32'(grid_height) > hbs_pkg::MAX_GRID_HEIGHT) ?
                 hbs_pkg::CFG_W'(hbs_pkg::MAX_GRID_HEIGHT) : grid_height;

  // ---------------------------------------------------------------------------
  // Front: cell decode and range check straight off the ports.
  // world / 4096 is the same bits read as Q.12, so the upper bits are the floored
  // cell and the low 12 are the fraction.
  // ---------------------------------------------------------------------------
  logic          accept, s1_valid, s1_ready, en1;
  logic [CW-1:0] cx_raw, cz_raw, w_lim, h_lim;
  logic          col_ok, row_ok, inr0;

  assign cx_raw = world_x[hbs_pkg::WORLD_W-1:hbs_pkg::GRID_FRAC];
  assign cz_raw = world_z[hbs_pkg::WORLD_W-1:hbs_pkg::GRID_FRAC];
  assign w_lim  = CW'(w_sat) - CW'(1);
  assign h_lim  = CW'(h_sat) - CW'(1);

  // negative cells have the top bit set; last row / column are excluded
  assign col_ok = !cx_raw[CW-1] && (w_sat >= hbs_pkg::CFG_W'(2)) && (cx_raw < w_lim);
  assign row_ok = !cz_raw[CW-1] && (h_sat >= hbs_pkg::CFG_W'(2)) && (cz_raw < h_lim);
  assign inr0   = col_ok && row_ok;

  // S1 advances when empty or when the read stage takes it
  assign en1      = !s1_valid || s1_ready;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // S1: row offset and column, then four corner addresses into the RAMs.
  // ---------------------------------------------------------------------------
  logic [AW-1:0]              row_off;
  logic [hbs_pkg::COL_W-1:0]  col;
  hbs_pkg::hbs_tag_t          s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= accept && (command == hbs_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      row_off    <= AW'(cz_raw[hbs_pkg::ROW_W-1:0]) * AW'(w_sat);
      col        <= cx_raw[hbs_pkg::COL_W-1:0];
      s1_tag.inr <= inr0;
      s1_tag.fx  <= hbs_pkg::frac_conv(world_x[hbs_pkg::GRID_FRAC-1:0]);
      s1_tag.fz  <= hbs_pkg::frac_conv(world_z[hbs_pkg::GRID_FRAC-1:0]);
    end
  end

  logic [AW-1:0] a00, a10, a01, a11;

  assign a00 = row_off + AW'(col);
  assign a10 = a00 + AW'(1);
  assign a01 = a00 + AW'(w_sat);
  assign a11 = a01 + AW'(1);

  // ---------------------------------------------------------------------------
  // Height store: two identical copies, each with two read ports, so all four
  // corners come back from a single read. Writes go to both copies at transfer time.
  // A query still in S1 reads on the edge it leaves, so a write that transfers
  // on that same edge (younger) is correctly not seen; in_ready holds off
  // writes while a query waits in S1.
  // ---------------------------------------------------------------------------
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [hbs_pkg::HEIGHT_W-1:0]  h00, h10, h01, h11;

  assign we    = accept && (command == hbs_pkg::CMD_WRITE) &&
                 (32'(cell_index) < hbs_pkg::STORE_DEPTH);
  assign waddr = AW'(cell_index);

  hbs_ram #(
    .WIDTH (hbs_pkg::HEIGHT_W),
    .DEPTH (hbs_pkg::STORE_DEPTH)
  ) u_ram_top (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (cell_height),
    .re     (s1_ready),
    .raddr0 (a00),
    .raddr1 (a10),
    .rdata0 (h00),
    .rdata1 (h10)
  );

  hbs_ram #(
    .WIDTH (hbs_pkg::HEIGHT_W),
    .DEPTH (hbs_pkg::STORE_DEPTH)
  ) u_ram_bot (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (cell_height),
    .re     (s1_ready),
    .raddr0 (a01),
    .raddr1 (a11),
    .rdata0 (h01),
    .rdata1 (h11)
  );

  // ---------------------------------------------------------------------------
  // Interpolation pipe and output register
  // ---------------------------------------------------------------------------
  hbs_lerp u_lerp (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_tag       (s1_tag),
    .s1_ready     (s1_ready),
    .h00          (h00),
    .h10          (h10),
    .h01          (h01),
    .h11          (h11),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .height_value (height_value),
    .in_range     (in_range)
  );

endmodule

`default_nettype wire
